// ===== src/fifo_queue_with_search_min_max_assert.svh =====
// assertion macros for the fifo queue with search, minimum and maximum
`ifndef FIFO_QUEUE_WITH_SEARCH_MIN_MAX_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_MIN_MAX_ASSERT_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define FQSMM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqsmm same-cycle check failed");
// condition implies consequence in the next cycle
`define FQSMM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqsmm next-cycle check failed");
`else
`define FQSMM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define FQSMM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/fqsmm_pkg.sv =====
// shared types and constants of the fifo queue with search, minimum and maximum
`default_nettype none

package fqsmm_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int VALUE_W   = 32;

   // opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic                      found;
      logic [3:0]                found_position;
      logic signed [VALUE_W-1:0] smallest;
      logic signed [VALUE_W-1:0] largest;
      logic [4:0]                entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OP,
      ST_SCAN,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

// ===== src/fqsmm_store.sv =====
// entry memory: one write port, one read port with registered read data
`default_nettype none

module fqsmm_store import fqsmm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic signed [VALUE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/fifo_queue_with_search_min_max.sv =====
// top level of the fifo queue with search, minimum and maximum
//
//   channel   ports                         direction  payload
//   request   req_valid req_stall req_data  in         opcode, value
//   response  rsp_valid rsp_stall rsp_data  out        status, removed value, search hit,
//                                                      min, max, count
//
// one item at a time: from transfer to result an item passes accept, operation,
// one read per held entry plus one step for the last read data, and result
// load; the entries are read one by one through the single read port.
// reset is synchronous; the queue comes out empty, the memory is not cleared
// a finished result waits in the output register, so the next item is taken
// while the response side stalls; it only holds in the load step if the
// output register is still full
`default_nettype none
`include "fifo_queue_with_search_min_max_assert.svh"

module fifo_queue_with_search_min_max import fqsmm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW  = $clog2(DEPTH);
   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam logic [CW-1:0]  FULL_COUNT = CW'(DEPTH);
   localparam logic [AW1-1:0] DEPTH_EXT  = AW1'(DEPTH);
   localparam logic [AW-1:0]  LAST_SLOT  = AW'(DEPTH - 1);

   // sequencer and queue pointers
   seq_state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;

   // item being worked on
   logic [1:0]                op_ff, op_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [1:0]                status_ff, status_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic                      found_ff, found_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;

   // tag that travels with each memory read
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_rem_ff, rd_rem_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // memory port controls
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic                      rd_is_remove;
   logic signed [VALUE_W-1:0] rd_data;

   logic          req_accept;
   logic          out_free;
   logic          load_rsp;
   logic          is_full;
   logic          is_empty;
   logic [AW1-1:0] scan_sum;
   logic [AW1-1:0] tail_sum;
   logic [AW-1:0]  scan_slot;
   logic [AW-1:0]  tail_slot;
   logic [AW-1:0]  head_step;
   logic [31:0]    count_wide;
   logic [31:0]    pos_wide;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_full    = (count_ff == FULL_COUNT);
   assign is_empty   = (count_ff == '0);

   // physical slots: head plus offset, wrapped once (the head stays below the depth, the offset does not exceed it)
   assign scan_sum  = {1'b0, head_ff} + AW1'(scan_ff);
   assign tail_sum  = {1'b0, head_ff} + AW1'(count_ff);
   assign scan_slot = (scan_sum >= DEPTH_EXT) ? AW'(scan_sum - DEPTH_EXT) : scan_sum[AW-1:0];
   assign tail_slot = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : tail_sum[AW-1:0];
   assign head_step = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);

   fqsmm_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // last read data is folded in at the edge that leaves this state
            if (scan_ff == count_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall    = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = tail_slot;
      rd_en        = 1'b0;
      rd_addr      = scan_slot;
      rd_is_remove = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_OP: begin
            // insert writes the tail slot; remove reads the head slot.
            // the scan reads start in ST_SCAN, after the write, so a new entry is already stored
            wr_en        = (op_ff == OP_INSERT) && !is_full;
            rd_en        = (op_ff == OP_REMOVE) && !is_empty;
            rd_addr      = head_ff;
            rd_is_remove = 1'b1;
         end
         ST_SCAN: begin
            rd_en = (scan_ff != count_ff);
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      min_in     = min_ff;
      max_in     = max_ff;

      if (req_accept) begin
         op_in      = req_data.opcode;
         val_in     = req_data.value;
         status_in  = STATUS_OK;
         removed_in = '0;
         found_in   = 1'b0;
         pos_in     = '0;
         min_in     = VALUE_MAX;
         max_in     = VALUE_MIN;
         scan_in    = '0;
      end

      if (state_ff == ST_OP) begin
         case (op_ff)
            OP_INSERT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            OP_REMOVE: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = head_step;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               // search and the unused code change nothing here
            end
         endcase
      end

      if ((state_ff == ST_SCAN) && rd_en) begin
         scan_in = scan_ff + CW'(1);
      end

      // read data phase: the removed entry, or one held entry in head order
      if (rd_vld_ff) begin
         if (rd_rem_ff) begin
            removed_in = rd_data;
         end else begin
            if (rd_data < min_ff) begin
               min_in = rd_data;
            end
            if (rd_data > max_ff) begin
               max_in = rd_data;
            end
            // first hit in head order is the oldest match
            if ((op_ff == OP_SEARCH) && !found_ff && (rd_data == val_ff)) begin
               found_in = 1'b1;
               pos_in   = rd_pos_ff;
            end
         end
      end
   end

   // read tag pipeline
   always_comb begin
      rd_vld_in = rd_en;
      rd_rem_in = rd_is_remove;
      rd_pos_in = AW'(scan_ff);
   end

   // output register
   assign count_wide = 32'(count_ff);
   assign pos_wide   = 32'(pos_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.status          = status_ff;
         rsp_data_in.removed_value   = removed_ff;
         rsp_data_in.found           = found_ff;
         rsp_data_in.found_position  = pos_wide[3:0];
         rsp_data_in.smallest        = min_ff;
         rsp_data_in.largest         = max_ff;
         rsp_data_in.entry_count     = count_wide[4:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      rd_rem_ff   <= rd_rem_in;
      rd_pos_ff   <= rd_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `FQSMM_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `FQSMM_ASSERT_NEXT(a_accept_to_op, clock, reset, req_accept, state_ff == ST_OP)
   `FQSMM_ASSERT_NEXT(a_load_shows_rsp, clock, reset, load_rsp, rsp_valid_ff)
   `FQSMM_ASSERT_SAME(a_no_port_clash, clock, reset, wr_en, !rd_en)

endmodule

`default_nettype wire
